// File: hw/rtl/ffud_pkg.sv
// ----------------------------------------------------------------------------
// ffud_pkg
// Shared types, character codes, status codes and helpers of the form field
// decoder.
// ----------------------------------------------------------------------------
package ffud_pkg;

   // Input transfer: one body byte
   typedef struct packed {
      logic [7:0] body_byte;
      logic       end_of_body;
   } req_type;

   // Result transfer: decoded byte or final status
   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] status;
      logic       last;
   } rsp_type;

   // Results of one body byte, oldest in entry 0
   localparam int unsigned RES_MAX = 3;

   typedef struct packed {
      logic [1:0]                 count;
      rsp_type [RES_MAX-1:0]      items;
   } res_type;

   // Register settings seen by the parser
   typedef struct packed {
      logic [63:0] key_chars_low;
      logic [63:0] key_chars_high;
      logic [4:0]  key_len;
      logic [10:0] buf_size;
   } cfg_type;

   // Register indexes
   localparam logic [1:0] CSR_KEY_LOW  = 2'd0;
   localparam logic [1:0] CSR_KEY_HIGH = 2'd1;
   localparam logic [1:0] CSR_KEY_LEN  = 2'd2;
   localparam logic [1:0] CSR_OUT_SIZE = 2'd3;

   // Status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND  = 3'd1;
   localparam logic [2:0] ST_BAD_ESCAPE = 3'd2;
   localparam logic [2:0] ST_TOO_LONG   = 3'd3;
   localparam logic [2:0] ST_ZERO       = 3'd4;

   // Characters
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_NUL   = 8'h00;

   localparam logic [4:0]  KEY_MAX   = 5'd16;
   localparam logic [10:0] LIMIT_MAX = 11'd1024;

   // Result queue
   localparam int unsigned FIFO_DEPTH = 8;
   localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   function automatic logic is_hex(input logic [7:0] c);
      is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = c - 8'h57;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = c - 8'h37;
      end
      hex_val = v[3:0];
   endfunction

   function automatic logic [7:0] plain(input logic [7:0] c);
      plain = (c == CH_PLUS) ? CH_SPACE : c;
   endfunction

   // Data item if the byte fits and is nonzero, else the failing status item
   function automatic rsp_type emit_item(input logic [10:0] cnt,
                                         input logic [10:0] lim,
                                         input logic [7:0]  b);
      rsp_type r;
      r = '0;
      if (({1'b0, cnt} + 12'd1) >= {1'b0, lim}) begin
         r.status = ST_TOO_LONG;
         r.last   = 1'b1;
      end else if (b == CH_NUL) begin
         r.status = ST_ZERO;
         r.last   = 1'b1;
      end else begin
         r.out_byte = b;
      end
      emit_item = r;
   endfunction

endpackage

// File: hw/rtl/ffud_parse.sv
// ----------------------------------------------------------------------------
// ffud_parse
// Field parser: name match, value decode, size check; up to three results
// per body byte.
// ----------------------------------------------------------------------------
module ffud_parse (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  ffud_pkg::req_type item,
   input  ffud_pkg::cfg_type cfg,
   output ffud_pkg::res_type res
);

   localparam logic [1:0] PH_NAME  = 2'd0;
   localparam logic [1:0] PH_VALUE = 2'd1;
   localparam logic [1:0] PH_SKIP  = 2'd2;
   localparam logic [1:0] PH_DONE  = 2'd3;

   localparam logic [1:0] ESC_NONE = 2'd0;
   localparam logic [1:0] ESC_PCT  = 2'd1;
   localparam logic [1:0] ESC_HELD = 2'd2;

   logic [1:0]  phase_ff, phase_in;
   logic [4:0]  pos_ff, pos_in;
   logic        match_ff, match_in;
   logic [1:0]  esc_ff, esc_in;
   logic [7:0]  held_ff, held_in;
   logic [10:0] cnt_ff, cnt_in;

   logic [15:0][7:0] key;
   logic [10:0]      lim;
   logic [7:0]       c;
   logic             end_req;
   logic             a_emit;
   logic [7:0]       a_byte;
   logic [1:0]       stage;
   logic [1:0]       n;
   ffud_pkg::rsp_type it;
   ffud_pkg::rsp_type [ffud_pkg::RES_MAX-1:0] items;

   assign key = {cfg.key_chars_high, cfg.key_chars_low};
   assign lim = (cfg.buf_size > ffud_pkg::LIMIT_MAX) ? ffud_pkg::LIMIT_MAX
                                                      : cfg.buf_size;
   assign c   = item.body_byte;

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      match_in = match_ff;
      esc_in   = esc_ff;
      held_in  = held_ff;
      cnt_in   = cnt_ff;
      n        = 2'd0;
      items    = '0;
      a_emit   = 1'b0;
      a_byte   = 8'h00;
      stage    = ESC_NONE;
      it       = '0;
      end_req  = item.end_of_body || (c == ffud_pkg::CH_NUL) ||
                 (phase_ff == PH_VALUE && c == ffud_pkg::CH_AMP);

      if (fire) begin
         // body byte
         if (phase_ff != PH_DONE && c != ffud_pkg::CH_NUL) begin
            unique case (phase_ff)
               PH_NAME: begin
                  if (c == ffud_pkg::CH_AMP) begin
                     pos_in   = 5'd0;
                     match_in = 1'b1;
                  end else if (c == ffud_pkg::CH_EQ) begin
                     if (match_ff && pos_ff == cfg.key_len &&
                         cfg.key_len <= ffud_pkg::KEY_MAX) begin
                        phase_in = PH_VALUE;
                        esc_in   = ESC_NONE;
                        cnt_in   = 11'd0;
                     end else begin
                        phase_in = PH_SKIP;
                     end
                  end else if (match_ff) begin
                     if (pos_ff < cfg.key_len && pos_ff < ffud_pkg::KEY_MAX &&
                         c == key[pos_ff[3:0]]) begin
                        pos_in = pos_ff + 5'd1;
                     end else begin
                        match_in = 1'b0;
                     end
                  end
               end
               PH_SKIP: begin
                  if (c == ffud_pkg::CH_AMP) begin
                     phase_in = PH_NAME;
                     pos_in   = 5'd0;
                     match_in = 1'b1;
                  end
               end
               PH_VALUE: begin
                  if (c != ffud_pkg::CH_AMP) begin
                     if (esc_ff == ESC_PCT) begin
                        held_in = c;
                        esc_in  = ESC_HELD;
                     end else if (esc_ff == ESC_HELD) begin
                        esc_in = ESC_NONE;
                        if (!ffud_pkg::is_hex(held_ff) || !ffud_pkg::is_hex(c)) begin
                           items[n] = '{out_byte: 8'h00,
                                        status: ffud_pkg::ST_BAD_ESCAPE,
                                        last: 1'b1};
                           n        = n + 2'd1;
                           phase_in = PH_DONE;
                        end else begin
                           a_emit = 1'b1;
                           a_byte = {ffud_pkg::hex_val(held_ff), ffud_pkg::hex_val(c)};
                        end
                     end else if (c == ffud_pkg::CH_PCT) begin
                        esc_in = ESC_PCT;
                     end else begin
                        a_emit = 1'b1;
                        a_byte = ffud_pkg::plain(c);
                     end
                  end
               end
               default: begin
               end
            endcase
         end

         if (a_emit) begin
            it       = ffud_pkg::emit_item(cnt_in, lim, a_byte);
            items[n] = it;
            n        = n + 2'd1;
            if (it.last) phase_in = PH_DONE;
            else         cnt_in   = cnt_in + 11'd1;
         end

         // end of value or body
         if (phase_in != PH_DONE && end_req) begin
            if (phase_in == PH_VALUE) begin
               stage  = esc_in;
               esc_in = ESC_NONE;
               if (stage != ESC_NONE) begin
                  it       = ffud_pkg::emit_item(cnt_in, lim, ffud_pkg::CH_PCT);
                  items[n] = it;
                  n        = n + 2'd1;
                  if (it.last) phase_in = PH_DONE;
                  else         cnt_in   = cnt_in + 11'd1;
               end
               if (phase_in != PH_DONE && stage == ESC_HELD) begin
                  it       = ffud_pkg::emit_item(cnt_in, lim, ffud_pkg::plain(held_in));
                  items[n] = it;
                  n        = n + 2'd1;
                  if (it.last) phase_in = PH_DONE;
                  else         cnt_in   = cnt_in + 11'd1;
               end
               if (phase_in != PH_DONE) begin
                  items[n] = '{out_byte: 8'h00, status: ffud_pkg::ST_OK, last: 1'b1};
                  n        = n + 2'd1;
                  phase_in = PH_DONE;
               end
            end else begin
               items[n] = '{out_byte: 8'h00, status: ffud_pkg::ST_NOT_FOUND,
                            last: 1'b1};
               n        = n + 2'd1;
               phase_in = PH_DONE;
            end
         end

         // next body starts clean
         if (item.end_of_body) begin
            phase_in = PH_NAME;
            pos_in   = 5'd0;
            match_in = 1'b1;
            esc_in   = ESC_NONE;
            held_in  = 8'h00;
            cnt_in   = 11'd0;
         end
      end
   end

   assign res.count = n;
   assign res.items = items;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NAME;
         pos_ff   <= 5'd0;
         match_ff <= 1'b1;
         esc_ff   <= ESC_NONE;
         held_ff  <= 8'h00;
         cnt_ff   <= 11'd0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         match_ff <= match_in;
         esc_ff   <= esc_in;
         held_ff  <= held_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// File: hw/rtl/ffud_rsp_fifo.sv
// ----------------------------------------------------------------------------
// ffud_rsp_fifo
// Result queue: takes up to three results a cycle, gives one a cycle when popped.
// ----------------------------------------------------------------------------
module ffud_rsp_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  ffud_pkg::res_type         push,
   input  logic                      pop,
   output logic                      valid,
   output ffud_pkg::rsp_type         head,
   output logic                      room
);

   ffud_pkg::rsp_type mem_ff [ffud_pkg::FIFO_DEPTH];

   logic [ffud_pkg::FIFO_AW-1:0] wr_ff, wr_in;
   logic [ffud_pkg::FIFO_AW-1:0] rd_ff, rd_in;
   logic [ffud_pkg::FIFO_CW-1:0] count_ff, count_in;

   assign valid = (count_ff != '0);
   assign head  = mem_ff[rd_ff];
   // room for a full burst of results, ignoring this cycle's pop
   assign room  = (count_ff <= ffud_pkg::FIFO_CW'(ffud_pkg::FIFO_DEPTH - ffud_pkg::RES_MAX));

   assign wr_in    = wr_ff + ffud_pkg::FIFO_AW'(push.count);
   assign rd_in    = rd_ff + ffud_pkg::FIFO_AW'(pop);
   assign count_in = count_ff + ffud_pkg::FIFO_CW'(push.count) - ffud_pkg::FIFO_CW'(pop);

   always_ff @(posedge clock) begin
      for (int i = 0; i < ffud_pkg::RES_MAX; i++) begin
         if (2'(i) < push.count) begin
            mem_ff[wr_ff + ffud_pkg::FIFO_AW'(i)] <= push.items[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: hw/rtl/form_field_url_decoder.sv
// ----------------------------------------------------------------------------
// form_field_url_decoder
// Extracts one field of a url-encoded form body and percent-decodes it.
// ----------------------------------------------------------------------------
// The block takes one body byte per cycle on req_. Each accepted byte lands in
// an input register; when the queue has room, the parser updates its state and
// writes zero to three results into an eight-entry result queue, whose head
// drives rsp_. Each result is registered in the queue before it shows. Most
// bytes give at most one result; the end of a value can give three (a held
// '%', the held character and the status). The input stalls only while the
// queue has fewer than three free entries, so one byte per cycle is sustained
// as long as the consumer drains about one result per cycle. The csr_ port
// is always ready; write it only while the block is idle.
// ----------------------------------------------------------------------------
module form_field_url_decoder (
   input  logic              clock,
   input  logic              reset,
   // body bytes
   input  logic              req_valid,
   output logic              req_stall,
   input  ffud_pkg::req_type req_data,
   // decoded bytes and status
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ffud_pkg::rsp_type rsp_data,
   // register writes
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [63:0]       csr_data
);

   // config registers
   logic [63:0] key_low_ff;
   logic [63:0] key_high_ff;
   logic [4:0]  key_len_ff;
   logic [10:0] out_size_ff;
   ffud_pkg::cfg_type cfg;

   // input register
   logic              in_valid_ff, in_valid_in;
   ffud_pkg::req_type in_item_ff;
   logic              accept;
   logic              fire;

   ffud_pkg::res_type res;
   logic              room;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= 64'd0;
         key_high_ff <= 64'd0;
         key_len_ff  <= 5'd0;
         out_size_ff <= 11'd65;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ffud_pkg::CSR_KEY_LOW:  key_low_ff  <= csr_data;
            ffud_pkg::CSR_KEY_HIGH: key_high_ff <= csr_data;
            ffud_pkg::CSR_KEY_LEN:  key_len_ff  <= csr_data[4:0];
            ffud_pkg::CSR_OUT_SIZE: out_size_ff <= csr_data[10:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg = '{key_chars_low:  key_low_ff,
                  key_chars_high: key_high_ff,
                  key_len:        key_len_ff,
                  buf_size:       out_size_ff};

   // The held byte is parsed once the queue can take a full burst; a new
   // transfer refills the register in the same cycle.
   assign fire        = in_valid_ff && room;
   assign req_stall   = in_valid_ff && !room;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_data;
      end
   end

   ffud_parse u_parse (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (in_item_ff),
      .cfg   (cfg),
      .res   (res)
   );

   ffud_rsp_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (res),
      .pop   (rsp_valid && !rsp_stall),
      .valid (rsp_valid),
      .head  (rsp_data),
      .room  (room)
   );

   // a burst of two or three results is a value end: data first, status last
   a_burst_order : assert property (@(posedge clock) disable iff (reset)
      (fire && res.count >= 2'd2) |->
         (!res.items[0].last && res.items[res.count - 2'd1].last))
      else $error("result burst not data then status");

   // status items carry a zero byte, data items an ok status
   a_item_form : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((rsp_data.last && rsp_data.out_byte == 8'h00) ||
          (!rsp_data.last && rsp_data.status == ffud_pkg::ST_OK)))
      else $error("malformed result item");

   // a byte waiting on the queue stays in the input register
   a_hold_input : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !fire) |=> (in_valid_ff && $stable(in_item_ff)))
      else $error("waiting input byte lost");

endmodule
